// ----- hdl/pdbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pdbfa_pkg: shared types and constants of the residue sequence extractor
// Token sizes, line modes, the character classes of the lexer and the
// three-letter to one-letter amino-acid tables.
// ----------------------------------------------------------------------------
package pdbfa_pkg;

  // Characters kept per token; the length saturates at this value.
  localparam int unsigned TokenChars = 8;
  localparam int unsigned LenW       = $clog2(TokenChars + 1);

  // Token counter after the first token of a line, saturating.
  localparam int unsigned NumW       = 3;
  localparam logic [NumW-1:0] NumSaturate = 3'd6;
  localparam logic [NumW-1:0] NumName     = 3'd3;
  localparam logic [NumW-1:0] NumResidue  = 3'd5;

  // Line modes.
  localparam int unsigned ModeW = 2;
  localparam logic [ModeW-1:0] ModeAwait = 2'd0;
  localparam logic [ModeW-1:0] ModeAtom  = 2'd1;
  localparam logic [ModeW-1:0] ModeSkip  = 2'd2;

  // Residue codes: 0..19 standard, twenty is unknown.
  localparam int unsigned CodeW = 5;
  localparam logic [CodeW-1:0] CodeUnknown = 5'd20;

  // Character classes.
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;

  typedef logic [TokenChars-1:0][7:0] tok_chars_t;

  // Current token and the kind of byte that arrives with it.
  typedef struct packed {
    logic            close_tok;   // byte ends the current token
    logic            close_line;  // byte ends the line
    tok_chars_t      chars;       // token characters, zero past the length
    logic [LenW-1:0] len;         // saturated token length
  } tok_t;

  // Looks up a three-character residue name.
  function automatic logic [CodeW-1:0] residue_code_f(input logic [23:0] name);
    logic [CodeW-1:0] code;
    begin
      case (name)
        "ALA":   code = 5'd0;
        "CYS":   code = 5'd1;
        "ASP":   code = 5'd2;
        "GLU":   code = 5'd3;
        "PHE":   code = 5'd4;
        "GLY":   code = 5'd5;
        "HIS":   code = 5'd6;
        "ILE":   code = 5'd7;
        "LYS":   code = 5'd8;
        "LEU":   code = 5'd9;
        "MET":   code = 5'd10;
        "ASN":   code = 5'd11;
        "PRO":   code = 5'd12;
        "GLN":   code = 5'd13;
        "ARG":   code = 5'd14;
        "SER":   code = 5'd15;
        "THR":   code = 5'd16;
        "VAL":   code = 5'd17;
        "TRP":   code = 5'd18;
        "TYR":   code = 5'd19;
        default: code = CodeUnknown;
      endcase
      return code;
    end
  endfunction

  // One-letter ASCII code of a standard residue.
  function automatic logic [6:0] residue_letter_f(input logic [CodeW-1:0] code);
    logic [7:0] ch;
    begin
      case (code)
        5'd0:    ch = "A";
        5'd1:    ch = "C";
        5'd2:    ch = "D";
        5'd3:    ch = "E";
        5'd4:    ch = "F";
        5'd5:    ch = "G";
        5'd6:    ch = "H";
        5'd7:    ch = "I";
        5'd8:    ch = "K";
        5'd9:    ch = "L";
        5'd10:   ch = "M";
        5'd11:   ch = "N";
        5'd12:   ch = "P";
        5'd13:   ch = "Q";
        5'd14:   ch = "R";
        5'd15:   ch = "S";
        5'd16:   ch = "T";
        5'd17:   ch = "V";
        5'd18:   ch = "W";
        5'd19:   ch = "Y";
        default: ch = "A";
      endcase
      return ch[6:0];
    end
  endfunction

endpackage

// ----- hdl/pdbfa_token.sv -----
// ----------------------------------------------------------------------------
// pdbfa_token: token accumulator
// Classifies each byte and collects token characters, saturating the length
// at the package token size. Presents the current token to the line logic.
// ----------------------------------------------------------------------------
module pdbfa_token import pdbfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,      // beat of the input stage is consumed
  input  logic [7:0] char_i,
  input  logic       eoi_i,
  output tok_t       tok_o
);

  tok_chars_t      chars_q, chars_d;
  logic [LenW-1:0] len_q, len_d;
  logic            is_line, is_sep;

  // Byte classes: newline or end of stream ends the line, whitespace splits.
  assign is_line = eoi_i || (char_i == ChLf);
  assign is_sep  = !eoi_i && ((char_i == ChSpace) || (char_i == ChTab) ||
                              (char_i == ChCr) || (char_i == ChVt) ||
                              (char_i == ChFf));

  assign tok_o.close_tok  = is_line || is_sep;
  assign tok_o.close_line = is_line;
  assign tok_o.chars      = chars_q;
  assign tok_o.len        = len_q;

  // Append a character or clear the token when it closes.
  always_comb begin
    chars_d = chars_q;
    len_d   = len_q;
    if (is_line || is_sep) begin
      chars_d = '0;
      len_d   = '0;
    end else if (len_q < LenW'(TokenChars)) begin
      for (int i = 0; i < TokenChars; i++) begin
        if (len_q == LenW'(i)) begin
          chars_d[i] = char_i;
        end
      end
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      len_q   <= '0;
    end else if (en_i) begin
      chars_q <= chars_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- hdl/pdbfa_line.sv -----
// ----------------------------------------------------------------------------
// pdbfa_line: record and residue tracking
// Follows the line mode and token count, takes the residue name and compares
// the residue number with the last stored one to decide on a new letter.
// ----------------------------------------------------------------------------
module pdbfa_line import pdbfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,      // beat of the input stage is consumed
  input  tok_t       tok_i,
  output logic       emit_o,
  output logic [6:0] letter_o
);

  logic [ModeW-1:0] mode_q, mode_d;
  logic [NumW-1:0]  num_q, num_d, num_inc;
  logic [CodeW-1:0] code_q, code_d;
  tok_chars_t       prev_chars_q, prev_chars_d;
  logic [LenW-1:0]  prev_len_q, prev_len_d;
  logic             tok_done, is_atom, same_num;

  assign tok_done = tok_i.close_tok && (tok_i.len != '0);
  assign is_atom  = (tok_i.len == LenW'(4)) &&
                    ({tok_i.chars[0], tok_i.chars[1], tok_i.chars[2], tok_i.chars[3]}
                     == "ATOM");
  assign same_num = (prev_len_q == tok_i.len) && (prev_chars_q == tok_i.chars);
  assign num_inc  = (num_q < NumSaturate) ? num_q + NumW'(1) : num_q;

  // Per-token decisions, then the end of line resets mode and count.
  always_comb begin
    mode_d       = mode_q;
    num_d        = num_q;
    code_d       = code_q;
    prev_chars_d = prev_chars_q;
    prev_len_d   = prev_len_q;
    emit_o       = 1'b0;
    if (tok_done) begin
      unique case (mode_q)
        ModeAwait: begin
          mode_d = is_atom ? ModeAtom : ModeSkip;
        end
        ModeAtom: begin
          num_d = num_inc;
          if (num_inc == NumName) begin
            code_d = (tok_i.len == LenW'(3)) ?
                     residue_code_f({tok_i.chars[0], tok_i.chars[1], tok_i.chars[2]}) :
                     CodeUnknown;
          end
          if ((num_inc == NumResidue) && !same_num) begin
            prev_chars_d = tok_i.chars;
            prev_len_d   = tok_i.len;
            emit_o       = (code_q != CodeUnknown);
          end
        end
        default: begin
        end
      endcase
    end
    if (tok_i.close_line) begin
      mode_d = ModeAwait;
      num_d  = '0;
    end
  end

  assign letter_o = residue_letter_f(code_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeAwait;
      num_q        <= '0;
      code_q       <= CodeUnknown;
      prev_chars_q <= '0;
      prev_len_q   <= '0;
    end else if (en_i) begin
      mode_q       <= mode_d;
      num_q        <= num_d;
      code_q       <= code_d;
      prev_chars_q <= prev_chars_d;
      prev_len_q   <= prev_len_d;
    end
  end

endmodule

// ----- hdl/pdb_atom_record_to_fasta_core.sv -----
// ----------------------------------------------------------------------------
// pdb_atom_record_to_fasta_core: ATOM record to one-letter sequence extractor
// Takes a text stream one byte per beat and emits the one-letter code of
// each new residue found on ATOM lines.
// ----------------------------------------------------------------------------
// A letter is registered at the output as its closing beat advances.
// Throughput: one byte per cycle while the output is free, set by the single
// input stage feeding token and line logic, whose state updates once per beat.
// Reset: asynchronous, active low; clears the stages, the token, the line
// mode, the residue code (unknown) and the stored residue number.
module pdb_atom_record_to_fasta_core import pdbfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic [0:0] s_axis_tuser_i,   // [0] end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [6:0] letter, [7] zero
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eoi_q;
  logic       out_free, advance;
  logic       out_valid_q;
  logic [6:0] out_letter_q;
  logic       emit;
  logic [6:0] letter;
  tok_t       tok;

  // The stage moves on whenever the output register can take a letter.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tuser_i[0];
    end
  end

  pdbfa_token u_token (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .char_i (in_char_q),
    .eoi_i  (in_eoi_q),
    .tok_o  (tok)
  );

  pdbfa_line u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .tok_i    (tok),
    .emit_o   (emit),
    .letter_o (letter)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_letter_q <= letter;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_letter_q};

`ifndef ASSERT_OFF
  // A letter in the output register is always an upper-case ASCII code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_letter_q >= 7'h41) && (out_letter_q <= 7'h59))
    else $error("letter out of range");

  // An emitted letter reaches the output register in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> out_valid_q)
    else $error("emitted letter lost");

  // A stalled input stage keeps its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(in_char_q) && $stable(in_eoi_q))
    else $error("input stage dropped a beat");

  // With room at the output the block always takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free |-> s_axis_tready_o)
    else $error("input stalled with a free output");
`endif

endmodule
